@@ sv/sorb_pkg.sv @@
// ----------------------------------------------------------------------------
// sorb_pkg
// Shared types and codes for the scan order rank builder.
// ----------------------------------------------------------------------------
package sorb_pkg;

    localparam int KEY_W  = 32;
    localparam int SKEY_W = 33;
    localparam int RANK_W = 6;
    localparam int POS_W  = 6;
    localparam int MODE_W = 3;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_REF    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_QUANT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RADIUS = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIAG   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HYPER  = 3'd4;

    typedef logic signed [SKEY_W-1:0] skey_t;
    typedef logic [RANK_W-1:0]        rank_t;

    typedef struct packed {
        logic valid;
        logic cap;
    } stream_ctrl_t;

endpackage

@@ sv/sorb_keygen.sv @@
// ----------------------------------------------------------------------------
// sorb_keygen
// Key store and sort key generator; feeds one key per cycle into the chain.
// ----------------------------------------------------------------------------
module sorb_keygen #(
    parameter int EDGE  = 8,
    parameter int DIMS  = 2,
    parameter int NCELL = 64,
    parameter int QW    = 6,
    parameter int AW    = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load_en,
    input  logic [AW-1:0]               load_addr,
    input  logic [sorb_pkg::KEY_W-1:0]  load_data,
    input  logic [sorb_pkg::MODE_W-1:0] mode,
    input  sorb_pkg::stream_ctrl_t      issue_ctrl,
    input  logic [QW-1:0]               issue_idx,
    output sorb_pkg::stream_ctrl_t      out_ctrl,
    output logic [QW-1:0]               out_idx,
    output sorb_pkg::skey_t             out_key
);

    localparam int CDW = (EDGE > 2) ? $clog2(EDGE) : 1;
    localparam int GW  = DIMS * (CDW + 1);

    typedef logic [DIMS-1:0][CDW-1:0] coords_t;

    logic [sorb_pkg::KEY_W-1:0] key_mem [0:NCELL-1];

    coords_t                   nxt_reg;
    coords_t                   nxt_next;
    coords_t                   base_c;
    sorb_pkg::stream_ctrl_t    st_ctrl_reg [0:DIMS];
    logic [QW-1:0]             st_q_reg    [0:DIMS];
    logic [GW-1:0]             st_acc_reg  [0:DIMS];
    coords_t                   st_c_reg    [0:DIMS];
    logic [GW-1:0]             acc_next    [0:DIMS-1];

    sorb_pkg::stream_ctrl_t    m_ctrl_reg;
    logic [QW-1:0]             m_q_reg;
    logic [GW-1:0]             m_acc_reg;
    logic [sorb_pkg::KEY_W-1:0] m_data_reg;

    sorb_pkg::stream_ctrl_t    o_ctrl_reg;
    logic [QW-1:0]             o_idx_reg;
    sorb_pkg::skey_t           o_key_reg;
    sorb_pkg::skey_t           key_sel;
    sorb_pkg::skey_t           mem_key;

    // coordinate counter: digit ripple over the dimensions
    always_comb
    begin
        logic carry;
        base_c   = (issue_idx == '0) ? coords_t'(0) : nxt_reg;
        nxt_next = base_c;
        carry    = 1'b1;
        for (int j = 0; j < DIMS; j++)
        begin
            if (carry)
            begin
                if (base_c[j] == CDW'(EDGE - 1))
                begin
                    nxt_next[j] = '0;
                end
                else
                begin
                    nxt_next[j] = base_c[j] + CDW'(1);
                    carry       = 1'b0;
                end
            end
        end
    end

    // one dimension folded in per stage
    always_comb
    begin
        logic [GW-1:0] c_ext;
        for (int j = 0; j < DIMS; j++)
        begin
            c_ext = GW'(st_c_reg[j][j]);
            case (mode)
                sorb_pkg::MODE_RADIUS: acc_next[j] = st_acc_reg[j] + GW'(c_ext * c_ext);
                sorb_pkg::MODE_DIAG:   acc_next[j] = st_acc_reg[j] + c_ext;
                sorb_pkg::MODE_HYPER:  acc_next[j] = GW'(st_acc_reg[j] * (c_ext + GW'(1)));
                default:               acc_next[j] = st_acc_reg[j];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= DIMS; j++)
            begin
                st_ctrl_reg[j] <= '0;
            end
            m_ctrl_reg <= '0;
            o_ctrl_reg <= '0;
        end
        else
        begin
            st_ctrl_reg[0] <= issue_ctrl;
            for (int j = 0; j < DIMS; j++)
            begin
                st_ctrl_reg[j+1] <= st_ctrl_reg[j];
            end
            m_ctrl_reg <= st_ctrl_reg[DIMS];
            o_ctrl_reg <= m_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_ctrl.valid)
        begin
            nxt_reg <= nxt_next;
        end
        st_q_reg[0]   <= issue_idx;
        st_c_reg[0]   <= base_c;
        st_acc_reg[0] <= (mode == sorb_pkg::MODE_HYPER) ? GW'(1) : '0;
        for (int j = 0; j < DIMS; j++)
        begin
            st_q_reg[j+1]   <= st_q_reg[j];
            st_c_reg[j+1]   <= st_c_reg[j];
            st_acc_reg[j+1] <= acc_next[j];
        end
        m_q_reg   <= st_q_reg[DIMS];
        m_acc_reg <= st_acc_reg[DIMS];
        o_idx_reg <= m_q_reg;
        o_key_reg <= key_sel;
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            key_mem[load_addr] <= load_data;
        end
        m_data_reg <= key_mem[st_q_reg[DIMS][AW-1:0]];
    end

    assign mem_key = $signed({m_data_reg[sorb_pkg::KEY_W-1], m_data_reg});

    always_comb
    begin
        case (mode)
            sorb_pkg::MODE_QUANT:  key_sel = -mem_key;
            sorb_pkg::MODE_RADIUS,
            sorb_pkg::MODE_DIAG,
            sorb_pkg::MODE_HYPER:  key_sel = -$signed(sorb_pkg::SKEY_W'(m_acc_reg));
            default:               key_sel = mem_key;
        endcase
    end

    assign out_ctrl = o_ctrl_reg;
    assign out_idx  = o_idx_reg;
    assign out_key  = o_key_reg;

endmodule

@@ sv/sorb_cell.sv @@
// ----------------------------------------------------------------------------
// sorb_cell
// One position of the rank chain: holds its key, counts keys that beat it.
// ----------------------------------------------------------------------------
module sorb_cell #(
    parameter int P  = 0,
    parameter int QW = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sorb_pkg::stream_ctrl_t in_ctrl,
    input  logic [QW-1:0]          in_idx,
    input  sorb_pkg::skey_t        in_key,
    output sorb_pkg::stream_ctrl_t out_ctrl,
    output logic [QW-1:0]          out_idx,
    output sorb_pkg::skey_t        out_key,
    input  logic                   shift_en,
    input  sorb_pkg::rank_t        count_in,
    output sorb_pkg::rank_t        count_out
);

    sorb_pkg::stream_ctrl_t ctrl_reg;
    logic [QW-1:0]          idx_reg;
    sorb_pkg::skey_t        skey_reg;
    sorb_pkg::skey_t        own_key_reg;
    sorb_pkg::rank_t        count_reg;
    sorb_pkg::rank_t        count_next;
    logic                   beats;

    assign beats = (in_idx != '0) &&
                   ((in_key > own_key_reg) ||
                    ((in_key == own_key_reg) && (in_idx < QW'(P))));

    always_comb
    begin
        count_next = count_reg;
        if (shift_en)
        begin
            count_next = count_in;
        end
        else if (in_ctrl.valid && in_ctrl.cap && (in_idx == QW'(P)))
        begin
            count_next = (P == 0) ? '0 : sorb_pkg::rank_t'(1);
        end
        else if (in_ctrl.valid && !in_ctrl.cap && (P != 0) && beats)
        begin
            count_next = count_reg + sorb_pkg::rank_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= in_idx;
        skey_reg  <= in_key;
        count_reg <= count_next;
        if (in_ctrl.valid && in_ctrl.cap && (in_idx == QW'(P)))
        begin
            own_key_reg <= in_key;
        end
    end

    assign out_ctrl  = ctrl_reg;
    assign out_idx   = idx_reg;
    assign out_key   = skey_reg;
    assign count_out = count_reg;

endmodule

@@ sv/scan_order_rank_builder_unit.sv @@
// ----------------------------------------------------------------------------
// scan_order_rank_builder_unit
// Builds a coefficient scan table by stable descending rank of sort keys.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start/operation/position/key and are taken when busy is
//   low. A load writes one key. A read gives its result on position_out/rank
//   with result_strobe high for one cycle, in the cycle after the transfer;
//   reads and loads may follow back to back, one a cycle.
//   A build raises busy, with NCELL = min(BLOCK, 64), for one pass to place
//   each key in its cell, one pass streaming all BLOCK keys through the cell
//   chain, the chain drain, and a shift of the counts out into the rank
//   table. The streaming pass feeds the chain one key per cycle.
//   order_mode is written through cfg_wr_en/cfg_wr_data; the user must write
//   it only while idle, as the block itself does not enforce that; a build
//   takes the mode at its transfer.
//   Reset clears control state and order_mode; the key store and rank table
//   hold nothing valid until loaded and built.
//   Results cannot be held off by the receiver; none is ever dropped.
// ----------------------------------------------------------------------------
module scan_order_rank_builder_unit #(
    parameter int EDGE = 8,
    parameter int DIMS = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [sorb_pkg::OP_W-1:0]   operation,
    input  logic [sorb_pkg::POS_W-1:0]  position,
    input  logic signed [sorb_pkg::KEY_W-1:0] key,
    input  logic                        cfg_wr_en,
    input  logic [sorb_pkg::MODE_W-1:0] cfg_wr_data,
    output logic                        result_strobe,
    output logic [sorb_pkg::POS_W-1:0]  position_out,
    output logic [sorb_pkg::RANK_W-1:0] rank
);

    localparam int BLOCK     = EDGE ** DIMS;
    localparam int NCELL     = (BLOCK < 64) ? BLOCK : 64;
    localparam int QW        = $clog2(BLOCK);
    localparam int AW        = $clog2(NCELL);
    localparam int DRAIN_LEN = DIMS + 3 + NCELL;
    localparam int CW        = $clog2(BLOCK + DRAIN_LEN + NCELL + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CAP   = 3'd1;
    localparam logic [2:0] S_CNT   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [CW-1:0]               cnt_reg;
    logic [CW-1:0]               cnt_next;
    logic [sorb_pkg::MODE_W-1:0] order_mode_reg;
    logic [sorb_pkg::MODE_W-1:0] build_mode_reg;

    logic                        accept;
    logic                        in_range;
    logic                        load_en;
    sorb_pkg::stream_ctrl_t      issue_ctrl;
    logic                        shift_en;

    sorb_pkg::stream_ctrl_t      ch_ctrl [0:NCELL];
    logic [QW-1:0]               ch_idx  [0:NCELL];
    sorb_pkg::skey_t             ch_key  [0:NCELL];
    sorb_pkg::rank_t             ch_cnt  [0:NCELL];

    sorb_pkg::rank_t             rank_mem [0:NCELL-1];
    sorb_pkg::rank_t             rank_rd_reg;
    logic                        strobe_reg;
    logic [sorb_pkg::POS_W-1:0]  pos_out_reg;
    logic                        in_range_reg;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign in_range = ({1'b0, position} < 7'(NCELL));
    assign load_en  = accept && (operation == sorb_pkg::OP_LOAD) && in_range;
    assign shift_en = (state_reg == S_SHIFT);

    always_comb
    begin
        issue_ctrl.valid = (state_reg == S_CAP) || (state_reg == S_CNT);
        issue_ctrl.cap   = (state_reg == S_CAP);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + CW'(1);
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept && (operation == sorb_pkg::OP_BUILD))
                begin
                    state_next = S_CAP;
                end
            end
            S_CAP:
            begin
                if (cnt_reg == CW'(NCELL - 1))
                begin
                    state_next = S_CNT;
                    cnt_next   = '0;
                end
            end
            S_CNT:
            begin
                if (cnt_reg == CW'(BLOCK - 1))
                begin
                    state_next = S_DRAIN;
                    cnt_next   = '0;
                end
            end
            S_DRAIN:
            begin
                if (cnt_reg == CW'(DRAIN_LEN - 1))
                begin
                    state_next = S_SHIFT;
                    cnt_next   = '0;
                end
            end
            S_SHIFT:
            begin
                if (cnt_reg == CW'(NCELL - 1))
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            order_mode_reg <= sorb_pkg::MODE_REF;
            build_mode_reg <= sorb_pkg::MODE_REF;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= accept && (operation == sorb_pkg::OP_READ);
            if (cfg_wr_en)
            begin
                order_mode_reg <= cfg_wr_data;
            end
            if (accept && (operation == sorb_pkg::OP_BUILD))
            begin
                build_mode_reg <= order_mode_reg;
            end
        end
    end

    sorb_keygen #(
        .EDGE  (EDGE),
        .DIMS  (DIMS),
        .NCELL (NCELL),
        .QW    (QW),
        .AW    (AW)
    ) u_keygen (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (load_en),
        .load_addr  (position[AW-1:0]),
        .load_data  (key),
        .mode       (build_mode_reg),
        .issue_ctrl (issue_ctrl),
        .issue_idx  (cnt_reg[QW-1:0]),
        .out_ctrl   (ch_ctrl[0]),
        .out_idx    (ch_idx[0]),
        .out_key    (ch_key[0])
    );

    assign ch_cnt[0] = '0;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        sorb_cell #(
            .P  (i),
            .QW (QW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_ctrl   (ch_ctrl[i]),
            .in_idx    (ch_idx[i]),
            .in_key    (ch_key[i]),
            .out_ctrl  (ch_ctrl[i+1]),
            .out_idx   (ch_idx[i+1]),
            .out_key   (ch_key[i+1]),
            .shift_en  (shift_en),
            .count_in  (ch_cnt[i]),
            .count_out (ch_cnt[i+1])
        );
    end

    // counts leave the far end of the chain, last position first
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            rank_mem[AW'(NCELL - 1) - cnt_reg[AW-1:0]] <= ch_cnt[NCELL];
        end
        rank_rd_reg  <= rank_mem[position[AW-1:0]];
        pos_out_reg  <= position;
        in_range_reg <= in_range;
    end

    assign result_strobe = strobe_reg;
    assign position_out  = pos_out_reg;
    assign rank          = in_range_reg ? rank_rd_reg : '0;

endmodule
